FILE: src/mtlv_pkg.sv
// Shared types and constants of the median tank level and volume block.
`default_nettype none
package mtlv_pkg;

    localparam int SMP_W      = 16;
    localparam int CNT_W      = 7;
    localparam int AREA_W     = 32;
    localparam int PROD_W     = 48;
    localparam int VOL_W      = 39;
    localparam int REM_W      = 10;
    localparam int DIVISOR    = 1000;
    localparam int QH_W       = VOL_W - SMP_W;
    localparam int LO_W       = REM_W + SMP_W;
    localparam int RECIP_W    = 64;
    localparam int RECIP_SHIFT = 38;
    localparam logic [AREA_W-1:0] RECIP_MUL = 32'h10624DD3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_FILL_W   = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LENGTH = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CONFIG = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT  = 3'd5;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd5;

    typedef struct packed {
        logic [SMP_W-1:0] sample;
        logic             ok;
        logic             last;
    } t_item;

    typedef struct packed {
        logic [SMP_W-1:0]        width;
        logic [SMP_W-1:0]        length;
        logic [SMP_W-1:0]        height;
        logic signed [SMP_W-1:0] offset;
        logic                    configured;
        logic [CNT_W-1:0]        limit;
    } t_cfg;

    typedef struct packed {
        logic             level_valid;
        logic [SMP_W-1:0] median;
        logic [CNT_W-1:0] good;
        logic [SMP_W-1:0] liquid;
        logic [VOL_W-1:0] volume;
        logic [VOL_W-1:0] capacity;
    } t_result;

endpackage
`default_nettype wire

FILE: src/mtlv_front.sv
// Front end: sample intake, burst position tagging and the item queue.
`default_nettype none
module mtlv_front #(
    parameter int SAMPLES_PER_BURST = 10
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [15:0]             i_sample_mm,
    input  wire logic                    i_sample_ok,
    output logic                         o_q_valid,
    output mtlv_pkg::t_item              o_q_item,
    input  wire logic                    i_q_pop
);
    import mtlv_pkg::*;

    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(SAMPLES_PER_BURST - 1);

    logic [CNT_W-1:0]    r_pos;
    t_item               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr;
    logic [Q_PTR_W-1:0]  r_rd;
    logic [Q_FILL_W-1:0] r_fill;
    logic                push;
    logic                last;

    assign o_ready   = (r_fill != Q_FILL_W'(Q_DEPTH));
    assign o_q_valid = (r_fill != '0);
    assign o_q_item  = r_q[r_rd];
    assign push      = i_valid && o_ready;
    assign last      = (r_pos == LAST_POS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_pos <= last ? '0 : r_pos + CNT_W'(1);
                r_wr  <= r_wr + Q_PTR_W'(1);
            end
            if (i_q_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (push && !i_q_pop) begin
                r_fill <= r_fill + Q_FILL_W'(1);
            end else if (!push && i_q_pop) begin
                r_fill <= r_fill - Q_FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr].sample <= i_sample_mm;
            r_q[r_wr].ok     <= i_sample_ok;
            r_q[r_wr].last   <= last;
        end
    end

endmodule
`default_nettype wire

FILE: src/mtlv_div.sv
// Two-lane divider by the millilitre constant using reciprocal multiplication.
`default_nettype none
module mtlv_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [1:0][mtlv_pkg::PROD_W-1:0]   i_dvd,
    output logic                                    o_done,
    output logic [1:0][mtlv_pkg::VOL_W-1:0]         o_quo
);
    import mtlv_pkg::*;

    localparam logic [1:0] STEP_HI  = 2'd0;
    localparam logic [1:0] STEP_REM = 2'd1;
    localparam logic [1:0] STEP_LO  = 2'd2;

    logic [1:0][PROD_W-1:0] r_x;
    logic [1:0][QH_W-1:0]   r_qh;
    logic [1:0][LO_W-1:0]   r_lo;
    logic [1:0][SMP_W-1:0]  r_ql;
    logic [1:0][QH_W-1:0]   qh;
    logic [1:0][LO_W-1:0]   lo;
    logic [1:0][SMP_W-1:0]  ql;
    logic [1:0]             r_step;
    logic                   r_busy;
    logic                   r_done;

    // Split each dividend into its upper 32 bits and lower 16 bits; the
    // remainder of the upper part joined to the lower part gives the low
    // 16 quotient bits.
    always_comb begin
        logic [AREA_W-1:0]  hi;
        logic [AREA_W-1:0]  op;
        logic [RECIP_W-1:0] prod;
        logic [AREA_W-1:0]  rem;
        for (int j = 0; j < 2; j++) begin
            hi    = r_x[j][PROD_W-1:SMP_W];
            op    = (r_step == STEP_LO) ? AREA_W'(r_lo[j]) : hi;
            prod  = RECIP_W'(op) * RECIP_W'(RECIP_MUL);
            qh[j] = prod[RECIP_SHIFT +: QH_W];
            ql[j] = prod[RECIP_SHIFT +: SMP_W];
            rem   = hi - AREA_W'(r_qh[j]) * AREA_W'(DIVISOR);
            lo[j] = {rem[REM_W-1:0], r_x[j][SMP_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_HI;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_HI;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == STEP_LO) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dvd;
        end else if (r_busy) begin
            case (r_step)
                STEP_HI:  r_qh <= qh;
                STEP_REM: r_lo <= lo;
                STEP_LO:  r_ql <= ql;
                default: begin
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_quo[0] = {r_qh[0], r_ql[0]};
    assign o_quo[1] = {r_qh[1], r_ql[1]};

endmodule
`default_nettype wire

FILE: src/mtlv_back.sv
// Back end: sorted sample store, burst counters, level and volume sequencer.
`default_nettype none
module mtlv_back #(
    parameter int SAMPLES_PER_BURST = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mtlv_pkg::t_cfg    i_cfg,
    input  wire logic              i_q_valid,
    input  wire mtlv_pkg::t_item   i_q_item,
    output logic                   o_q_pop,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output mtlv_pkg::t_result      o_res
);
    import mtlv_pkg::*;

    localparam int N     = SAMPLES_PER_BURST;
    localparam int IDX_W = (N > 1) ? $clog2(N) : 1;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_EVAL     = 3'd1;
    localparam logic [2:0] ST_MUL_VOL  = 3'd2;
    localparam logic [2:0] ST_MUL_CAP  = 3'd3;
    localparam logic [2:0] ST_DIV_GO   = 3'd4;
    localparam logic [2:0] ST_DIV_WAIT = 3'd5;
    localparam logic [2:0] ST_PUSH     = 3'd6;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [SMP_W-1:0]  r_buf [N];
    logic [SMP_W-1:0]  n_buf [N];
    logic [N-1:0]      stay;
    logic [CNT_W-1:0]  r_good;
    logic [CNT_W-1:0]  r_failed;
    logic              r_ok;
    logic [SMP_W-1:0]  r_med;
    logic [SMP_W-1:0]  r_liq;
    logic [CNT_W-1:0]  r_res_good;
    logic [AREA_W-1:0] r_area;
    logic [PROD_W-1:0] r_pvol;
    logic [PROD_W-1:0] r_pcap;

    logic [CNT_W-1:0]  half;
    logic [IDX_W-1:0]  med_idx;
    logic [SMP_W-1:0]  med_sel;
    logic [17:0]       sum;
    logic [17:0]       diff;
    logic [SMP_W-1:0]  liq;
    logic              accept_ok;

    logic [AREA_W-1:0] mul_a;
    logic [SMP_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;

    logic                   div_done;
    logic [1:0][VOL_W-1:0]  div_quo;

    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            stay[i] = (CNT_W'(i) < r_good) && (r_buf[i] <= i_q_item.sample);
        end
        for (int i = 0; i < N; i++) begin
            if (stay[i]) begin
                n_buf[i] = r_buf[i];
            end else if (i == 0) begin
                n_buf[i] = i_q_item.sample;
            end else if (stay[(i > 0) ? i - 1 : 0]) begin
                n_buf[i] = i_q_item.sample;
            end else begin
                n_buf[i] = r_buf[(i > 0) ? i - 1 : 0];
            end
        end
    end

    assign half      = r_good >> 1;
    assign med_idx   = half[IDX_W-1:0];
    assign med_sel   = r_buf[med_idx];
    assign sum       = {2'b00, med_sel} + {{2{i_cfg.offset[SMP_W-1]}}, i_cfg.offset};
    assign diff      = {2'b00, i_cfg.height} - sum;
    assign accept_ok = i_cfg.configured && (r_good != '0) && (r_failed <= i_cfg.limit);

    always_comb begin
        if (diff[17]) begin
            liq = '0;
        end else if (diff[16:0] > {1'b0, i_cfg.height}) begin
            liq = i_cfg.height;
        end else begin
            liq = diff[SMP_W-1:0];
        end
    end

    always_comb begin
        mul_a = {16'b0, i_cfg.width};
        mul_b = i_cfg.length;
        case (r_state)
            ST_MUL_VOL: begin
                mul_a = r_area;
                mul_b = r_liq;
            end
            ST_MUL_CAP: begin
                mul_a = r_area;
                mul_b = i_cfg.height;
            end
            default: begin
                mul_a = {16'b0, i_cfg.width};
                mul_b = i_cfg.length;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && i_q_item.last) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL:     n_state = accept_ok ? ST_MUL_VOL : ST_PUSH;
            ST_MUL_VOL:  n_state = ST_MUL_CAP;
            ST_MUL_CAP:  n_state = ST_DIV_GO;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_good   <= '0;
            r_failed <= '0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                if (i_q_item.ok) begin
                    r_good <= r_good + CNT_W'(1);
                end else begin
                    r_failed <= r_failed + CNT_W'(1);
                end
            end else if (r_state == ST_EVAL) begin
                r_good   <= '0;
                r_failed <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_item.ok) begin
            for (int i = 0; i < N; i++) begin
                r_buf[i] <= n_buf[i];
            end
        end
        if (r_state == ST_EVAL) begin
            r_ok       <= accept_ok;
            r_med      <= med_sel;
            r_liq      <= liq;
            r_res_good <= r_good;
            r_area     <= mul_p[AREA_W-1:0];
        end
        if (r_state == ST_MUL_VOL) begin
            r_pvol <= mul_p;
        end
        if (r_state == ST_MUL_CAP) begin
            r_pcap <= mul_p;
        end
    end

    mtlv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DIV_GO),
        .i_dvd   ({r_pcap, r_pvol}),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_res_valid       = (r_state == ST_PUSH);
    assign o_res.level_valid = r_ok;
    assign o_res.median      = r_ok ? r_med : '0;
    assign o_res.good        = r_ok ? r_res_good : '0;
    assign o_res.liquid      = r_ok ? r_liq : '0;
    assign o_res.volume      = r_ok ? div_quo[0] : '0;
    assign o_res.capacity    = r_ok ? div_quo[1] : '0;

endmodule
`default_nettype wire

FILE: src/median_tank_level_volume.sv
// Top level of the median-filtered tank level and volume block.
// Input channel: one beat per distance sample (i_sample_mm, i_sample_ok) on
// i_valid/o_ready. Every SAMPLES_PER_BURST beats form a burst; the good
// samples go into a sorted store, one insertion per cycle while the
// sequencer is idle, and failed ones are counted.
// Output channel: one beat per burst on o_valid/i_ready carrying the level,
// the upper median, the good count and the liquid and full volumes.
// A two-entry queue sits between intake and processing, so samples are taken
// one per cycle while processing keeps up.
// After the last sample of a burst leaves the queue, an accepted burst passes
// an evaluation state, two states on the shared 32x16 multiplier, one that
// starts the divide by 1000, the three divider steps, one that sees it finish
// and the push state that loads the output register.
// Meanwhile intake takes up to two more samples before o_ready drops.
// The result sits in an output register; while the receiver stalls it holds
// and the next burst's samples are still sorted; a second finished result
// waits in the sequencer, which then stops taking samples.
// Configuration is written on i_cfg_we/i_cfg_addr/i_cfg_data with no wait.
// Reset empties the queue, clears the burst counters and o_valid and
// loads the register defaults; the sample store needs no clearing.
`default_nettype none
module median_tank_level_volume #(
    parameter int SAMPLES_PER_BURST = 10
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [mtlv_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [mtlv_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [15:0]                        i_sample_mm,
    input  wire logic                               i_sample_ok,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic                                    o_level_valid,
    output logic [15:0]                             o_median_mm,
    output logic [6:0]                              o_good_count,
    output logic [15:0]                             o_liquid_height_mm,
    output logic [38:0]                             o_volume_ml,
    output logic [38:0]                             o_capacity_ml
);
    import mtlv_pkg::*;

    t_cfg    r_cfg;
    logic    q_valid;
    t_item   q_item;
    logic    q_pop;
    logic    res_valid;
    logic    res_ready;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width      <= '0;
            r_cfg.length     <= '0;
            r_cfg.height     <= '0;
            r_cfg.offset     <= '0;
            r_cfg.configured <= 1'b0;
            r_cfg.limit      <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_WIDTH:  r_cfg.width      <= i_cfg_data;
                REG_LENGTH: r_cfg.length     <= i_cfg_data;
                REG_HEIGHT: r_cfg.height     <= i_cfg_data;
                REG_OFFSET: r_cfg.offset     <= $signed(i_cfg_data);
                REG_CONFIG: r_cfg.configured <= i_cfg_data[0];
                REG_LIMIT:  r_cfg.limit      <= i_cfg_data[CNT_W-1:0];
                default:    r_cfg.limit      <= r_cfg.limit;
            endcase
        end
    end

    mtlv_front #(
        .SAMPLES_PER_BURST (SAMPLES_PER_BURST)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample_mm (i_sample_mm),
        .i_sample_ok (i_sample_ok),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    mtlv_back #(
        .SAMPLES_PER_BURST (SAMPLES_PER_BURST)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_level_valid      = r_out.level_valid;
    assign o_median_mm        = r_out.median;
    assign o_good_count       = r_out.good;
    assign o_liquid_height_mm = r_out.liquid;
    assign o_volume_ml        = r_out.volume;
    assign o_capacity_ml      = r_out.capacity;

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_level_valid |->
            o_median_mm == '0 && o_good_count == '0 && o_liquid_height_mm == '0 &&
            o_volume_ml == '0 && o_capacity_ml == '0)
        else $error("rejected burst carries nonzero fields");

    a_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_level_valid |->
            o_good_count != '0 && o_good_count <= CNT_W'(SAMPLES_PER_BURST))
        else $error("accepted burst with good count out of range");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule
`default_nettype wire
